// ----- rtl/core/xo256p_pkg.sv -----
// Package for the xoshiro256+ generator: constants, sequencer states and helpers.
package xo256p_pkg;

   // Data widths
   localparam int WORD_W     = 64;
   localparam int HALF_W     = WORD_W / 2;
   localparam int NUM_WORDS  = 4;
   localparam int WIDX_W     = $clog2(NUM_WORDS);
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // Register map: seed_value at byte address 0, registers spaced by 8 bytes
   localparam int CSR_SEL_BIT = 3;
   localparam logic CSR_IDX_SEED = 1'b0;

   // Generator constants
   localparam logic [WORD_W-1:0] SEED_RESET   = 64'd1;
   localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
   localparam int SHIFT_T = 17;
   localparam int ROT_W3  = 45;
   localparam int MIX_SH1 = 30;
   localparam int MIX_SH2 = 27;
   localparam int MIX_SH3 = 31;

   // Partial-product phases of the shared 32x32 multiplier
   localparam int PHASE_W = 2;
   localparam logic [PHASE_W-1:0] PH_LO_LO = 2'd0;
   localparam logic [PHASE_W-1:0] PH_HI_LO = 2'd1;
   localparam logic [PHASE_W-1:0] PH_LO_HI = 2'd2;

   // Reseed sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAMMA,
      ST_MUL_A,
      ST_XOR27,
      ST_MUL_B,
      ST_XOR31,
      ST_DRAW
   } seq_state_type;

   typedef logic [WORD_W-1:0] word_type;

   // Rotate left by a constant amount
   function automatic word_type rotl(input word_type x, input int k);
      return (x << k) | (x >> (WORD_W - k));
   endfunction

endpackage : xo256p_pkg

// ----- rtl/core/xoshiro256_plus_generator_core.sv -----
// xoshiro256+ generator: registered draws, iterative splitmix64 reseed on one shared multiplier.
//
// Each transfer on the req_ channel yields one 64-bit value on the rsp_ channel. A draw with
// req_restart low forms the value and the next state from the four state registers at accept
// time; the value lands in the output register, and the next request is taken as soon as that
// register is free or being emptied. A draw with req_restart high first reseeds the state from
// seed_value with four splitmix64 outputs, then draws; the reseed is paced by a single 32x32
// multiplier that builds each 64-bit product from three partial products. Per word it runs a
// gamma add, a multiply, an xor-shift, a second multiply and a final xor-shift; the draw then
// waits until the output register is free, and req_ready stays low throughout. After reset
// the same reseed from seed 1 runs before the first request is taken. Writes to seed_value
// change only the register; it is used at the next restart.
module xoshiro256_plus_generator_core
   import xo256p_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_restart,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_W-1:0]     rsp_random_value,
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   seq_state_type        state_ff, state_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [WIDX_W-1:0]    widx_ff, widx_in;
   logic                 draw_pend_ff, draw_pend_in;
   word_type             seed_ff;
   word_type             ctr_ff, ctr_in;
   word_type             z_ff, z_in;
   word_type             acc_ff, acc_in;
   word_type             word_ff [NUM_WORDS];
   logic                 word_we;
   word_type             word_wdata;
   logic                 draw_en;
   logic                 rsp_valid_ff, rsp_valid_in;
   word_type             rsp_value_ff;

   // Shared multiplier
   word_type             mul_const;
   logic [HALF_W-1:0]    mul_x, mul_y;
   word_type             mul_prod;

   // Draw datapath
   word_type             draw_value;
   word_type             t_sh, n0, n1, n2, n3;
   word_type             gamma_sum;

   logic                 out_free;
   logic                 req_xfer;
   logic                 csr_wr;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_SEL_BIT] == CSR_IDX_SEED);
   assign csr_prdata = (csr_paddr[CSR_SEL_BIT] == CSR_IDX_SEED) ? seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_wr) begin
         seed_ff <= csr_pwdata;
      end
   end

   // Handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   // Output value and xoshiro256 state transition
   assign draw_value = word_ff[0] + word_ff[3];
   assign t_sh = word_ff[1] << SHIFT_T;
   assign n2   = word_ff[2] ^ word_ff[0];
   assign n3   = word_ff[3] ^ word_ff[1];
   assign n1   = word_ff[1] ^ n2;
   assign n0   = word_ff[0] ^ n3;

   // Shared 32x32 multiplier: low product, then two cross terms into the upper half
   assign mul_const = (state_ff == ST_MUL_A) ? MIX_MUL_A : MIX_MUL_B;
   assign mul_x     = (phase_ff == PH_HI_LO) ? z_ff[WORD_W-1:HALF_W] : z_ff[HALF_W-1:0];
   assign mul_y     = (phase_ff == PH_LO_HI) ? mul_const[WORD_W-1:HALF_W]
                                             : mul_const[HALF_W-1:0];
   assign mul_prod  = WORD_W'(mul_x) * WORD_W'(mul_y);

   assign gamma_sum = ctr_ff + GOLDEN_GAMMA;

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      widx_in      = widx_ff;
      draw_pend_in = draw_pend_ff;
      ctr_in       = ctr_ff;
      z_in         = z_ff;
      acc_in       = acc_ff;
      word_we      = 1'b0;
      word_wdata   = acc_ff ^ (acc_ff >> MIX_SH3);
      draw_en      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_restart) begin
                  ctr_in       = seed_ff;
                  widx_in      = '0;
                  draw_pend_in = 1'b1;
                  state_in     = ST_GAMMA;
               end else begin
                  draw_en      = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_GAMMA: begin
            ctr_in   = gamma_sum;
            z_in     = gamma_sum ^ (gamma_sum >> MIX_SH1);
            phase_in = PH_LO_LO;
            state_in = ST_MUL_A;
         end
         ST_MUL_A, ST_MUL_B: begin
            if (phase_ff == PH_LO_LO) begin
               acc_in = mul_prod;
            end else begin
               acc_in = acc_ff + {mul_prod[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            if (phase_ff == PH_LO_HI) begin
               phase_in = PH_LO_LO;
               state_in = (state_ff == ST_MUL_A) ? ST_XOR27 : ST_XOR31;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_XOR27: begin
            z_in     = acc_ff ^ (acc_ff >> MIX_SH2);
            state_in = ST_MUL_B;
         end
         ST_XOR31: begin
            word_we = 1'b1;
            widx_in = widx_ff + 1'b1;
            if (widx_ff == WIDX_W'(NUM_WORDS - 1)) begin
               state_in = draw_pend_ff ? ST_DRAW : ST_IDLE;
            end else begin
               state_in = ST_GAMMA;
            end
         end
         ST_DRAW: begin
            if (out_free) begin
               draw_en      = 1'b1;
               rsp_valid_in = 1'b1;
               draw_pend_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers; reset starts a reseed from the reset seed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_GAMMA;
         phase_ff     <= PH_LO_LO;
         widx_ff      <= '0;
         draw_pend_ff <= 1'b0;
         ctr_ff       <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         widx_ff      <= widx_in;
         draw_pend_ff <= draw_pend_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      z_ff   <= z_in;
      acc_ff <= acc_in;
      if (draw_en) begin
         rsp_value_ff <= draw_value;
         word_ff[0]   <= n0;
         word_ff[1]   <= n1;
         word_ff[2]   <= n2 ^ t_sh;
         word_ff[3]   <= rotl(n3, ROT_W3);
      end else if (word_we) begin
         word_ff[widx_ff] <= word_wdata;
      end
   end

endmodule : xoshiro256_plus_generator_core

// ----- rtl/core/xo256p_checker.sv -----
// Port-level checks for the xoshiro256+ generator, bound to the top level.
module xo256p_checker
   import xo256p_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_restart,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_random_value
);

   // A stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_value))
      else $error("result changed while stalled");

   // The reseed after reset keeps requests out
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("request taken during reset reseed");

   // A restart transfer starts a reseed, so the next cycle takes nothing
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_restart |=> !req_ready)
      else $error("request taken during restart reseed");

   // A plain draw shows its result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_restart |=> rsp_valid)
      else $error("plain draw result missing");

endmodule : xo256p_checker

bind xoshiro256_plus_generator_core xo256p_checker u_xo256p_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_restart      (req_restart),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_random_value (rsp_random_value)
);
